/* design/ede_pkg.sv */
// Package for the edit distance engine.
// Holds the fixed field widths shared by the top level and the cost cell.
// No dependencies.
package ede_pkg;

    localparam int SYM_W = 8;   // width of one sequence symbol
    localparam int OUT_W = 12;  // width of the distance and similarity results

    typedef logic [SYM_W-1:0] t_symbol;
    typedef logic [OUT_W-1:0] t_result;

endpackage

/* design/ede_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ede_cell.sv */
// Cost cell of the edit distance row update: match or one plus the least neighbor.
// Depends on ede_pkg for the symbol type.
module ede_cell import ede_pkg::*; #(
    parameter int CW = 11
) (
    input  t_symbol         i_row_sym,
    input  t_symbol         i_col_sym,
    input  logic [CW-1:0]   i_diag,
    input  logic [CW-1:0]   i_above,
    input  logic [CW-1:0]   i_left,
    output logic [CW-1:0]   o_cost
);

    logic [CW-1:0] n_min_ab;
    logic [CW-1:0] n_min;
    logic [CW:0]   n_inc;

    always_comb begin
        n_min_ab = (i_diag < i_above) ? i_diag : i_above;
        n_min    = (n_min_ab < i_left) ? n_min_ab : i_left;
        n_inc    = {1'b0, n_min} + {{CW{1'b0}}, 1'b1};
        // The cost never exceeds the longer sequence, so the carry is always clear.
        o_cost   = (i_row_sym == i_col_sym) ? i_diag : n_inc[CW-1:0];
    end

endmodule

/* design/edit_distance_engine.sv */
// Edit distance engine top level: sequence store, cost row walk and result logic.
// Depends on ede_pkg, ede_ram and ede_cell.
//
// This block computes the unit-cost Levenshtein distance between two byte
// sequences. Each command transfer (start high while busy is low) carries one
// item. Items with i_mode low append a symbol of the first sequence; they
// never raise busy. Items with i_mode high bring one symbol of the second
// sequence and update the whole cost row against the stored first sequence:
// such an item keeps busy high until the row walk is done, so a new item can
// follow only after it. The cost row memory is read one entry per cycle as
// the row is walked. The item with i_mode high and i_last high ends the pair;
// the final cost entry is then read in a final state. The result is shown for
// exactly one cycle with o_valid high, and the block is then cleared for the
// next pair. Because the receiver cannot hold results off, a result transfer
// always completes in that cycle. Symbols beyond MAX_LEN in either sequence
// are dropped and reported by o_overflow. Both memories need no clearing
// after reset: every entry is written before it is read.
module edit_distance_engine import ede_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  logic    i_mode,
    input  t_symbol i_symbol,
    input  logic    i_has_symbol,
    input  logic    i_last,
    output logic    o_valid,
    output t_result o_distance,
    output t_result o_similarity,
    output logic    o_overflow
);

    // Length counters hold up to MAX_LEN; costs never exceed that either.
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int XW  = (LW + 1 > OUT_W) ? LW + 1 : OUT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state;
    logic [LW-1:0] r_fl;       // first sequence length
    logic [LW-1:0] r_sl;       // second sequence length
    logic          r_ovf;
    t_symbol       r_sym;      // symbol of the row being computed
    logic          r_first;    // the row above is the implicit initial row
    logic          r_last;
    logic          r_issue;    // reads still to be issued for this row
    logic [LW-1:0] r_rd_j;     // column whose entries are being read
    logic          r_cv;       // read data valid for the compute stage
    logic [LW-1:0] r_cj;       // column in the compute stage
    logic [LW-1:0] r_diag;
    logic [LW-1:0] r_left;
    logic          r_valid;
    t_result       r_dist;
    t_result       r_sim;
    logic          r_ovf_out;

    logic           n_accept;
    logic           n_row_start;
    logic           n_row_done;
    logic           n_emit_now;
    logic [LW-1:0]  n_cost;
    logic [LW-1:0]  n_above;
    logic [LW-1:0]  n_dist;
    logic [LW:0]    n_sim_w;
    logic [XW-1:0]  n_dist_x;
    logic [XW-1:0]  n_sim_x;

    logic           n_seq_we;
    t_symbol        n_seq_rdata;
    logic [SAW-1:0] n_seq_raddr;
    logic [LW-1:0]  n_sj;

    logic           n_cost_we;
    logic [LW-1:0]  n_cost_waddr;
    logic [LW-1:0]  n_cost_wdata;
    logic [LW-1:0]  n_cost_raddr;
    logic [LW-1:0]  n_cost_rdata;

    assign busy     = (r_state != S_IDLE);
    assign n_accept = start && !busy;

    // A second-sequence symbol with room left starts a row walk.
    assign n_row_start = n_accept && i_mode && i_has_symbol && (r_sl < LW'(MAX_LEN));
    // With no second-sequence symbol yet, the distance is the first length.
    assign n_emit_now  = n_accept && i_mode && i_last && !n_row_start && (r_sl == '0);
    assign n_row_done  = (r_state == S_ROW) && !r_issue && !r_cv;

    // First sequence store.
    assign n_seq_we    = n_accept && !i_mode && i_has_symbol && (r_sl == '0)
                         && (r_fl < LW'(MAX_LEN));
    assign n_sj        = r_rd_j - LW'(1);
    assign n_seq_raddr = n_sj[SAW-1:0];

    ede_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (n_seq_we),
        .i_waddr (r_fl[SAW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (n_seq_raddr),
        .o_rdata (n_seq_rdata)
    );

    // Cost row. Entry zero is written when a row starts; the other entries are
    // written by the compute stage in the cycle after their read. When no row is
    // being read, the read port looks at the final entry of the row.
    always_comb begin
        n_cost_we    = n_row_start || r_cv;
        n_cost_waddr = n_row_start ? '0 : r_cj;
        n_cost_wdata = n_row_start ? (r_sl + LW'(1)) : n_cost;
        n_cost_raddr = ((r_state == S_ROW) && r_issue) ? r_rd_j : r_fl;
    end

    ede_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_LEN + 1)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (n_cost_we),
        .i_waddr (n_cost_waddr),
        .i_wdata (n_cost_wdata),
        .i_raddr (n_cost_raddr),
        .o_rdata (n_cost_rdata)
    );

    // On the first row the entry above is simply its column number.
    assign n_above = r_first ? r_cj : n_cost_rdata;

    ede_cell #(
        .CW (LW)
    ) u_cell (
        .i_row_sym (r_sym),
        .i_col_sym (n_seq_rdata),
        .i_diag    (r_diag),
        .i_above   (n_above),
        .i_left    (r_left),
        .o_cost    (n_cost)
    );

    // Result arithmetic, masked to the output width.
    always_comb begin
        n_dist   = (r_state == S_FIN) ? n_cost_rdata : r_fl;
        n_sim_w  = {1'b0, r_fl} + {1'b0, r_sl} - {1'b0, n_dist};
        n_dist_x = XW'(n_dist);
        n_sim_x  = XW'(n_sim_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fl    <= '0;
            r_sl    <= '0;
            r_ovf   <= 1'b0;
            r_issue <= 1'b0;
            r_cv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (!i_mode) begin
                            if (i_has_symbol && (r_sl == '0)) begin
                                if (r_fl < LW'(MAX_LEN)) begin
                                    r_fl <= r_fl + LW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                        end else if (n_row_start) begin
                            r_sl    <= r_sl + LW'(1);
                            r_sym   <= i_symbol;
                            r_first <= (r_sl == '0);
                            r_last  <= i_last;
                            r_diag  <= r_sl;
                            r_left  <= r_sl + LW'(1);
                            r_issue <= (r_fl != '0);
                            r_rd_j  <= LW'(1);
                            r_cv    <= 1'b0;
                            r_state <= S_ROW;
                        end else begin
                            if (i_has_symbol) begin
                                r_ovf <= 1'b1;
                            end
                            if (n_emit_now) begin
                                r_valid   <= 1'b1;
                                r_dist    <= n_dist_x[OUT_W-1:0];
                                r_sim     <= n_sim_x[OUT_W-1:0];
                                r_ovf_out <= r_ovf;
                                r_fl      <= '0;
                                r_sl      <= '0;
                                r_ovf     <= 1'b0;
                            end else if (i_last) begin
                                // The final entry is being read this cycle.
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_ROW: begin
                    if (r_issue) begin
                        r_cv <= 1'b1;
                        r_cj <= r_rd_j;
                        if (r_rd_j == r_fl) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_j <= r_rd_j + LW'(1);
                        end
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (r_cv) begin
                        r_diag <= n_above;
                        r_left <= n_cost;
                    end
                    if (n_row_done) begin
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    r_valid   <= 1'b1;
                    r_dist    <= n_dist_x[OUT_W-1:0];
                    r_sim     <= n_sim_x[OUT_W-1:0];
                    r_ovf_out <= r_ovf;
                    r_fl      <= '0;
                    r_sl      <= '0;
                    r_ovf     <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_distance   = r_dist;
    assign o_similarity = r_sim;
    assign o_overflow   = r_ovf_out;

`ifndef ASSERT_OFF
    // Lengths never pass the capacity of the stores.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fl <= LW'(MAX_LEN)) && (r_sl <= LW'(MAX_LEN)))
        else $error("sequence length beyond MAX_LEN");

    // The compute stage only runs during a row walk.
    a_cv_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_state == S_ROW))
        else $error("cost compute outside a row walk");

    // A shown result means the pair state was cleared.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((r_fl == '0) && (r_sl == '0) && !r_ovf))
        else $error("pair state not cleared after a result");

    // First-sequence symbols are stored only before the second sequence starts.
    a_seq_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_seq_we |-> ((r_state == S_IDLE) && (r_sl == '0)))
        else $error("first sequence written after the second began");

    // Leaving the final-read state always produces a result.
    a_fin_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_valid)
        else $error("final state without a result");
`endif

endmodule
